@@ design/ata_taskfile_command_builder_core_defines.svh @@
// ----------------------------------------------------------------------------
// ATA task-file builder assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef ATA_TASKFILE_COMMAND_BUILDER_CORE_DEFINES_SVH
`define ATA_TASKFILE_COMMAND_BUILDER_CORE_DEFINES_SVH

// assertion that is disabled while reset is asserted
`define ATCB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that is also checked during reset
`define ATCB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/atcb_pkg.sv @@
// ----------------------------------------------------------------------------
// ATA task-file builder package
// Register codes, opcodes, constants and the descriptor type.
// ----------------------------------------------------------------------------
package atcb_pkg;

	// task-file register selects, in emission order
	typedef enum logic [3:0] {
		REG_CTRL     = 4'd0,
		REG_DEVSEL   = 4'd1,
		REG_COUNT_HI = 4'd2,
		REG_LBA3     = 4'd3,
		REG_LBA4     = 4'd4,
		REG_LBA5     = 4'd5,
		REG_COUNT_LO = 4'd6,
		REG_LBA0     = 4'd7,
		REG_LBA1     = 4'd8,
		REG_LBA2     = 4'd9,
		REG_CMD      = 4'd10
	} reg_sel_t;

	typedef enum logic [1:0] {
		ADDR_CHS   = 2'd0,
		ADDR_LBA28 = 2'd1,
		ADDR_LBA48 = 2'd2
	} addr_mode_t;

	// configuration register indexes
	localparam logic [1:0] CFG_SLAVE   = 2'd0;
	localparam logic [1:0] CFG_CHANNEL = 2'd1;
	localparam logic [1:0] CFG_LBA28   = 2'd2;

	localparam logic [3:0] SLAVE_MASK_RST   = 4'd10;
	localparam logic [3:0] CHANNEL_MASK_RST = 4'd12;
	localparam logic [3:0] LBA28_MASK_RST   = 4'd15;

	// ATA opcodes
	localparam logic [7:0] CMD_READ_PIO      = 8'h20;
	localparam logic [7:0] CMD_WRITE_PIO     = 8'h30;
	localparam logic [7:0] CMD_READ_PIO_EXT  = 8'h24;
	localparam logic [7:0] CMD_WRITE_PIO_EXT = 8'h34;

	localparam logic [7:0] CTRL_NIEN   = 8'h02;
	localparam logic [7:0] DEVSEL_CHS  = 8'hA0;
	localparam logic [7:0] DEVSEL_LBA  = 8'hE0;

	// CHS geometry: divide by sectors per track with a reciprocal
	localparam int          LBA28_BITS  = 28;
	localparam int          CHS_SPT     = 63;
	localparam int          RECIP_BITS  = 29;
	localparam int          RECIP_SHIFT = 34;
	localparam logic [RECIP_BITS-1:0] RECIP_SPT = 29'd272696337;
	localparam int          QUOT_BITS   = 23;

	// one request, ready to serialize
	typedef struct packed {
		addr_mode_t       addr;
		logic             chan;
		logic [7:0]       devsel;
		logic [7:0]       cmd;
		logic [15:0]      cnt;
		logic [5:0][7:0]  bytes;
	} desc_t;

endpackage

@@ design/atcb_serializer.sv @@
// ----------------------------------------------------------------------------
// ATA task-file write serializer
// Holds one request; emits its register writes one per cycle when not stalled.
// ----------------------------------------------------------------------------
module atcb_serializer import atcb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        desc_valid,
	input  desc_t       desc,
	output logic        desc_ready,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // target_register, write_value, high_order,
	                               // channel, addressing
	output logic        m_tlast
);

	desc_t      desc_q;
	logic       busy_q;
	reg_sel_t   step_q;
	logic       out_v_q;
	reg_sel_t   tgt_q;
	logic [7:0] val_q;
	logic       hob_q;
	logic       chan_q;
	addr_mode_t addr_q;
	logic       last_q;

	logic       out_free;
	logic       emit;
	logic       load;
	reg_sel_t   step_nxt;
	logic [7:0] step_val;
	logic       step_hob;

	assign out_free   = !out_v_q || m_tready;
	assign emit       = busy_q && out_free;
	assign desc_ready = !busy_q || (emit && step_q == REG_CMD);
	assign load       = desc_valid && desc_ready;

	// next register; short sequences skip the HOB bank
	always_comb begin
		if (step_q == REG_DEVSEL && desc_q.addr != ADDR_LBA48) begin
			step_nxt = REG_COUNT_LO;
		end else begin
			step_nxt = reg_sel_t'(step_q + 4'd1);
		end
	end

	// byte for the current register
	always_comb begin
		step_hob = 1'b0;
		case (step_q)
			REG_CTRL:     step_val = CTRL_NIEN;
			REG_DEVSEL:   step_val = desc_q.devsel;
			REG_COUNT_HI: begin
				step_val = desc_q.cnt[15:8];
				step_hob = 1'b1;
			end
			REG_LBA3: begin
				step_val = desc_q.bytes[3];
				step_hob = 1'b1;
			end
			REG_LBA4: begin
				step_val = desc_q.bytes[4];
				step_hob = 1'b1;
			end
			REG_LBA5: begin
				step_val = desc_q.bytes[5];
				step_hob = 1'b1;
			end
			REG_COUNT_LO: step_val = desc_q.cnt[7:0];
			REG_LBA0:     step_val = desc_q.bytes[0];
			REG_LBA1:     step_val = desc_q.bytes[1];
			REG_LBA2:     step_val = desc_q.bytes[2];
			REG_CMD:      step_val = desc_q.cmd;
			default:      step_val = 8'h00;
		endcase
	end

	// sequencing control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			step_q  <= REG_CTRL;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				step_q <= REG_CTRL;
			end else if (emit) begin
				if (step_q == REG_CMD) begin
					busy_q <= 1'b0;
				end
				step_q <= step_nxt;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// descriptor and output payload
	always_ff @(posedge clk) begin
		if (load) begin
			desc_q <= desc;
		end
		if (emit) begin
			tgt_q  <= step_q;
			val_q  <= step_val;
			hob_q  <= step_hob;
			chan_q <= desc_q.chan;
			addr_q <= desc_q.addr;
			last_q <= (step_q == REG_CMD);
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {addr_q, chan_q, hob_q, val_q, tgt_q};
	assign m_tlast  = last_q;

endmodule

@@ design/ata_taskfile_command_builder_core.sv @@
// ----------------------------------------------------------------------------
// ATA task-file command builder
// Turns a sector request into the ordered task-file register writes that
// start a PIO transfer: control, device select, counts and address bytes
// (HOB bank first for 48-bit addresses), then the opcode. Three pipeline
// stages (capture and drive lookup, divide-by-63 multiply, CHS/LBA byte
// build) feed a serializer that emits one register write per cycle while
// the output is not stalled: 11 writes per request in 48-bit mode and 7 in
// LBA28 or CHS mode; that serializer sets the sustained rate. Requests are
// accepted every cycle until the three stage registers are full, and each
// goes through them and the serializer's descriptor and output registers.
// ----------------------------------------------------------------------------
module ata_taskfile_command_builder_core import atcb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // mode, drive, block_address, sector_count
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // target_register, write_value, high_order,
	                               // channel, addressing
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);

	logic [3:0] slave_mask_q;
	logic [3:0] channel_mask_q;
	logic [3:0] lba28_mask_q;

	// input fields
	logic        in_mode;
	logic [1:0]  in_drive;
	logic [47:0] in_lba;
	logic [15:0] in_cnt;

	assign in_mode  = s_tdata[0];
	assign in_drive = s_tdata[2:1];
	assign in_lba   = s_tdata[50:3];
	assign in_cnt   = s_tdata[66:51];

	// stage registers
	logic        v_s1, v_s2, v_s3;
	logic        mode_s1, slave_s1, chan_s1, lbaok_s1;
	logic [47:0] lba_s1;
	logic [15:0] cnt_s1;
	logic        mode_s2, slave_s2, chan_s2;
	addr_mode_t  addr_s2;
	logic [47:0] lba_s2;
	logic [15:0] cnt_s2;
	logic [QUOT_BITS-1:0] quot_s2;
	desc_t       desc_s3;

	logic en1, en2, en3, desc_ready;

	assign en3      = !v_s3 || desc_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_mask_q   <= SLAVE_MASK_RST;
			channel_mask_q <= CHANNEL_MASK_RST;
			lba28_mask_q   <= LBA28_MASK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SLAVE:   slave_mask_q   <= cfg_data;
				CFG_CHANNEL: channel_mask_q <= cfg_data;
				CFG_LBA28:   lba28_mask_q   <= cfg_data;
				default:     ;
			endcase
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// stage 1: capture, per-drive flags
	always_ff @(posedge clk) begin
		if (en1) begin
			mode_s1  <= in_mode;
			lba_s1   <= in_lba;
			cnt_s1   <= in_cnt;
			slave_s1 <= slave_mask_q[in_drive];
			chan_s1  <= channel_mask_q[in_drive];
			lbaok_s1 <= lba28_mask_q[in_drive];
		end
	end

	// stage 2: addressing mode, quotient by sectors per track
	logic [LBA28_BITS+RECIP_BITS-1:0] prod;

	assign prod = {{RECIP_BITS{1'b0}}, lba_s1[LBA28_BITS-1:0]} *
	              {{LBA28_BITS{1'b0}}, RECIP_SPT};

	always_ff @(posedge clk) begin
		if (en2) begin
			mode_s2  <= mode_s1;
			slave_s2 <= slave_s1;
			chan_s2  <= chan_s1;
			lba_s2   <= lba_s1;
			cnt_s2   <= cnt_s1;
			quot_s2  <= prod[RECIP_SHIFT+QUOT_BITS-1:RECIP_SHIFT];
			if (|lba_s1[47:LBA28_BITS]) begin
				addr_s2 <= ADDR_LBA48;
			end else if (lbaok_s1) begin
				addr_s2 <= ADDR_LBA28;
			end else begin
				addr_s2 <= ADDR_CHS;
			end
		end
	end

	// stage 3: CHS geometry and task-file bytes
	logic [LBA28_BITS-1:0] quot_x63;
	logic [LBA28_BITS-1:0] rem_full;
	logic [7:0]            sect;
	logic [3:0]            head;
	desc_t                 desc_nxt;

	assign quot_x63 = LBA28_BITS'({quot_s2, 6'b0} - {6'b0, quot_s2});
	assign rem_full = lba_s2[LBA28_BITS-1:0] - quot_x63;
	assign sect     = {2'b00, rem_full[5:0]} + 8'd1;

	always_comb begin
		desc_nxt.addr  = addr_s2;
		desc_nxt.chan  = chan_s2;
		desc_nxt.cnt   = cnt_s2;
		desc_nxt.bytes = lba_s2;
		head           = 4'd0;
		case (addr_s2)
			ADDR_LBA48: begin
				desc_nxt.cmd = mode_s2 ? CMD_WRITE_PIO_EXT : CMD_READ_PIO_EXT;
			end
			ADDR_LBA28: begin
				desc_nxt.cmd = mode_s2 ? CMD_WRITE_PIO : CMD_READ_PIO;
				head         = lba_s2[27:24];
			end
			default: begin
				desc_nxt.cmd      = mode_s2 ? CMD_WRITE_PIO : CMD_READ_PIO;
				head              = quot_s2[3:0];
				desc_nxt.bytes[0] = sect;
				desc_nxt.bytes[1] = quot_s2[11:4];
				desc_nxt.bytes[2] = quot_s2[19:12];
			end
		endcase
		desc_nxt.devsel = ((addr_s2 == ADDR_CHS) ? DEVSEL_CHS : DEVSEL_LBA) |
		                  {3'b000, slave_s2, head};
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			desc_s3 <= desc_nxt;
		end
	end

	// register write sequencer
	atcb_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (v_s3),
		.desc       (desc_s3),
		.desc_ready (desc_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

@@ design/atcb_checker.sv @@
// ----------------------------------------------------------------------------
// ATA task-file builder checker
// Port-level checks on the register write stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "ata_taskfile_command_builder_core_defines.svh"

module atcb_checker import atcb_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// stalled item holds
	`ATCB_ASSERT(a_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output item changed while stalled")

	// sequence ends exactly on the command write
	`ATCB_ASSERT(a_last, clk, arst_n, m_tvalid |-> (m_tlast == (m_tdata[3:0] == REG_CMD)), "tlast not on command write")

	// HOB flag only on the high-order bank
	`ATCB_ASSERT(a_hob, clk, arst_n, m_tvalid |-> (m_tdata[12] == ((m_tdata[3:0] >= REG_COUNT_HI) && (m_tdata[3:0] <= REG_LBA5))), "HOB flag on wrong register")

	// control write always disables interrupts
	`ATCB_ASSERT(a_ctrl, clk, arst_n, m_tvalid && (m_tdata[3:0] == REG_CTRL) |-> (m_tdata[11:4] == CTRL_NIEN), "bad control value")

	// nothing presented in reset
	`ATCB_ASSERT_ALWAYS(a_rst, clk, !arst_n |-> !m_tvalid, "output valid during reset")

endmodule

bind ata_taskfile_command_builder_core atcb_checker u_atcb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
